@@ rtl/b64lw_pkg.sv @@
package b64lw_pkg;

    // payload words on the two channels
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_data;
    } t_in_word;

    typedef struct packed {
        logic [7:0] out_char;
        logic       run_last;
    } t_out_word;

    // one group of work handed from front to back
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] nbytes;
        logic       crlf;
    } t_job;

    localparam logic [7:0] BPL_RESET = 8'd18;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_CR  = 8'h0D;
    localparam logic [7:0] CHAR_LF  = 8'h0A;

    // character slots within one job
    localparam logic [2:0] STEP_S0 = 3'd0;
    localparam logic [2:0] STEP_S1 = 3'd1;
    localparam logic [2:0] STEP_S2 = 3'd2;
    localparam logic [2:0] STEP_S3 = 3'd3;
    localparam logic [2:0] STEP_CR = 3'd4;
    localparam logic [2:0] STEP_LF = 3'd5;

    localparam logic [8*64-1:0] ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // sextet to base64 symbol, first character sits in the top byte
    function automatic logic [7:0] b64_sym(input logic [5:0] v);
        logic [5:0] idx;
        idx = 6'd63 - v;
        return ALPHABET[{idx, 3'b000} +: 8];
    endfunction

endpackage

@@ rtl/b64lw_front.sv @@
module b64lw_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [7:0]         i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  b64lw_pkg::t_in_word i_in_word,
    input  logic               i_q_full,
    output logic               o_push,
    output b64lw_pkg::t_job    o_job
);
    import b64lw_pkg::*;

    logic [7:0]  r_blocks_per_line;
    logic [15:0] r_held_bytes;
    logic [1:0]  r_held_count;
    logic [7:0]  r_blocks_on_line;

    logic [15:0] n_held_bytes;
    logic [1:0]  n_held_count;
    logic [7:0]  n_blocks_on_line;

    logic       accept;
    logic       full_group;
    logic       last;
    logic [7:0] blk_inc;
    logic       line_full;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign full_group = (r_held_count == 2'd2);
    assign last       = i_in_word.end_of_data;
    assign blk_inc    = r_blocks_on_line + 8'd1;
    assign line_full  = (blk_inc >= r_blocks_per_line);

    // build the group job, missing bytes zero-filled
    always_comb begin
        o_job.b0     = (r_held_count == 2'd0) ? i_in_word.data_byte : r_held_bytes[15:8];
        o_job.b1     = full_group ? r_held_bytes[7:0] :
                       ((r_held_count == 2'd1) ? i_in_word.data_byte : 8'd0);
        o_job.b2     = full_group ? i_in_word.data_byte : 8'd0;
        o_job.nbytes = r_held_count + 2'd1;
        o_job.crlf   = (full_group && line_full) || (last && (blk_inc != 8'd0));
    end

    assign o_push = accept && (full_group || last);

    // next held bytes and line position
    always_comb begin
        n_held_bytes     = r_held_bytes;
        n_held_count     = r_held_count;
        n_blocks_on_line = r_blocks_on_line;
        if (accept) begin
            priority if (last) begin
                n_held_count     = 2'd0;
                n_blocks_on_line = 8'd0;
            end else if (full_group) begin
                n_held_count     = 2'd0;
                n_blocks_on_line = line_full ? 8'd0 : blk_inc;
            end else begin
                n_held_count = r_held_count + 2'd1;
                if (r_held_count == 2'd0) begin
                    n_held_bytes[15:8] = i_in_word.data_byte;
                end else begin
                    n_held_bytes[7:0] = i_in_word.data_byte;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blocks_per_line <= BPL_RESET;
            r_held_count      <= 2'd0;
            r_blocks_on_line  <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                r_blocks_per_line <= i_cfg_wdata;
            end
            r_held_count     <= n_held_count;
            r_blocks_on_line <= n_blocks_on_line;
        end
    end

    // held payload
    always_ff @(posedge i_clk) begin
        r_held_bytes <= n_held_bytes;
    end

endmodule

@@ rtl/b64lw_queue.sv @@
module b64lw_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64lw_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output b64lw_pkg::t_job o_head
);
    import b64lw_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
    localparam logic [CW-1:0] COUNT_MAX = CW'(DEPTH);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == COUNT_MAX);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

@@ rtl/b64lw_back.sv @@
module b64lw_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_head_valid,
    input  b64lw_pkg::t_job      i_head,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output b64lw_pkg::t_out_word o_out_word
);
    import b64lw_pkg::*;

    logic [2:0] r_step;
    logic       r_out_valid;
    t_out_word  r_out_word;

    logic       load;
    logic       step_last;
    logic [7:0] char_sel;
    logic [5:0] s0, s1, s2, s3;

    assign load      = i_head_valid && (!r_out_valid || i_out_ready);
    assign step_last = (r_step == (i_head.crlf ? STEP_LF : STEP_S3));
    assign o_pop     = load && step_last;

    // sextets of the group
    assign s0 = i_head.b0[7:2];
    assign s1 = {i_head.b0[1:0], i_head.b1[7:4]};
    assign s2 = {i_head.b1[3:0], i_head.b2[7:6]};
    assign s3 = i_head.b2[5:0];

    // character for the current slot
    always_comb begin
        unique case (r_step)
            STEP_S0: char_sel = b64_sym(s0);
            STEP_S1: char_sel = b64_sym(s1);
            STEP_S2: char_sel = (i_head.nbytes > 2'd1) ? b64_sym(s2) : CHAR_PAD;
            STEP_S3: char_sel = (i_head.nbytes > 2'd2) ? b64_sym(s3) : CHAR_PAD;
            STEP_CR: char_sel = CHAR_CR;
            STEP_LF: char_sel = CHAR_LF;
            default: char_sel = CHAR_PAD;
        endcase
    end

    // slot counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_S0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step      <= step_last ? STEP_S0 : r_step + 3'd1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_word.out_char <= char_sel;
            r_out_word.run_last <= step_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/base64_line_wrapped_encoder.sv @@
// channel   direction  handshake                  payload
// cfg       in         i_cfg_we                   i_cfg_wdata (blocks per line)
// in        in         i_in_valid / o_in_ready    i_in_word  (data_byte, end_of_data)
// out       out        o_out_valid / i_out_ready  o_out_word (out_char, run_last)
//
// a byte is taken every cycle while the group queue has room; the back end puts
// out one character per cycle while a group waits and the output is not stalled,
// so a group gives four characters, or six with carriage return and line feed
// a group's first character is registered at the output after the group is queued
// synchronous active-low reset clears held count, line position, queue and output
// out stall holds the word; in stalls only when QUEUE_DEPTH groups wait
module base64_line_wrapped_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [7:0]           i_cfg_wdata,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  b64lw_pkg::t_in_word  i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output b64lw_pkg::t_out_word o_out_word
);
    import b64lw_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job job_in;
    t_job job_head;

    // byte gathering and line bookkeeping
    b64lw_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (job_in)
    );

    // group queue between front and back
    b64lw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (job_head)
    );

    // character sequencer
    b64lw_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (job_head),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_word   (o_out_word)
    );

endmodule

@@ rtl/b64lw_checker.sv @@
module b64lw_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input b64lw_pkg::t_out_word o_out_word
);
    import b64lw_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed while stalled");

    // line feed follows carriage return in the very next word
    a_cr_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out_word.out_char == CHAR_CR
        |=> o_out_valid && o_out_word.out_char == CHAR_LF)
        else $error("carriage return not followed by line feed");

    // line feed always closes the run of one group
    a_lf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.out_char == CHAR_LF |-> o_out_word.run_last)
        else $error("line feed without run end");

    // carriage return never closes a run
    a_cr_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.out_char == CHAR_CR |-> !o_out_word.run_last)
        else $error("run ends on carriage return");

endmodule

bind base64_line_wrapped_encoder b64lw_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word)
);
